// File: rtl/vertex_scale_rotate_offset_defines.svh
// Assertion macros for the vertex transform block.
// Used by rtl/vertex_scale_rotate_offset.sv; needs i_clk and i_rst_n in scope.
`ifndef VERTEX_SCALE_ROTATE_OFFSET_DEFINES_SVH
`define VERTEX_SCALE_ROTATE_OFFSET_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge outside reset.
`define VSRO_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every clock edge outside reset.
`define VSRO_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VSRO_ASSERT_IMP(name, ante, cons, msg)
`define VSRO_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

// File: rtl/vsro_pkg.sv
// Package for the vertex transform block: item types, register codes,
// datapath widths and the output saturation function. No dependencies.
`default_nettype none

package vsro_pkg;

    // Coordinate and fixed-point settings.
    localparam int COORD_BITS       = 16;  // 8 .. 32
    localparam int TRIG_FRAC_BITS   = 14;  // 8 .. 30
    localparam int HEIGHT_FRAC_BITS = 8;
    localparam int REG_W            = 16;
    localparam int FOV_W            = 10;
    localparam int OUT_W            = 24;
    localparam int DEPTH_STEP       = 500;
    // Depth offset (fov + 2) * 500 stays below 2^19 for a 10-bit fov.
    localparam int DEPTH_W          = 19;
    localparam int NUM_STAGES       = 7;

    // Register indexes on the configuration port.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_PITCH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_PITCH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_YAW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COS_YAW       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_OF_VIEW = 3'd5;

    // Register reset values.
    localparam logic signed [REG_W-1:0] RST_GAIN = 16'sd256;
    localparam logic signed [REG_W-1:0] RST_SIN  = 16'sd0;
    localparam logic signed [REG_W-1:0] RST_COS  = 16'sd16384;
    localparam logic [DEPTH_W-1:0]      RST_DEPTH_OFFSET = DEPTH_W'(3 * DEPTH_STEP);

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Datapath widths, each just wide enough for its full-precision value.
    localparam int ZG_W      = COORD_BITS + REG_W;                     // z * gain
    localparam int ZS_W      = ZG_W + 1 - HEIGHT_FRAC_BITS;            // scaled z
    localparam int PC_W      = COORD_BITS + REG_W;                     // coord * trig
    localparam int PZ_W      = ZS_W + REG_W;                           // zs * trig
    localparam int R1_SUM_W  = imax(PC_W, PZ_W) + 2;
    localparam int R1_W      = R1_SUM_W - TRIG_FRAC_BITS;              // y1, z1
    localparam int PZ1_W     = R1_W + REG_W;                           // z1 * trig
    localparam int X2_SUM_W  = imax(imax(PC_W, PZ1_W) + 2, TRIG_FRAC_BITS + 2);
    localparam int X2_W      = X2_SUM_W - TRIG_FRAC_BITS;
    localparam int Z2_SUM_W  = imax(imax(PC_W, PZ1_W) + 1,
                                    DEPTH_W + TRIG_FRAC_BITS + 1) + 2;
    localparam int Z2_W      = Z2_SUM_W - TRIG_FRAC_BITS;
    localparam int SAT_W     = imax(imax(X2_W, R1_W), imax(Z2_W, OUT_W));

    // One input item.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_in;
        logic signed [COORD_BITS-1:0] y_in;
        logic signed [COORD_BITS-1:0] z_in;
        logic                         last_vertex;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [OUT_W-1:0] x_out;
        logic signed [OUT_W-1:0] y_out;
        logic signed [OUT_W-1:0] z_out;
        logic                    last_out;
    } t_out_item;

    // Register values as the datapath sees them.
    typedef struct packed {
        logic signed [REG_W-1:0] height_gain;
        logic signed [REG_W-1:0] sin_pitch;
        logic signed [REG_W-1:0] cos_pitch;
        logic signed [REG_W-1:0] sin_yaw;
        logic signed [REG_W-1:0] cos_yaw;
        logic [DEPTH_W-1:0]      depth_offset;
    } t_cfg;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2**(OUT_W-1) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    // Clamp a wide signed value into the output range.
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
        logic signed [OUT_W-1:0] res;
        if (v > SAT_HI) begin
            res = OUT_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            res = OUT_W'(SAT_LO);
        end else begin
            res = OUT_W'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/vsro_cfg_regs.sv
// Configuration register file for the vertex transform block.
// Depends on vsro_pkg for register codes, reset values and t_cfg.
`default_nettype none

module vsro_cfg_regs
    import vsro_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [REG_W-1:0]     i_wr_data,
    output t_cfg                      o_cfg
);

    t_cfg               r_cfg;
    logic [FOV_W:0]     fov_plus2;
    logic [DEPTH_W-1:0] n_depth_offset;

    // The field of view is kept only as its depth offset (fov + 2) * 500.
    assign fov_plus2      = (FOV_W+1)'(i_wr_data[FOV_W-1:0]) + (FOV_W+1)'(2);
    assign n_depth_offset = DEPTH_W'(DEPTH_W'(fov_plus2) * DEPTH_W'(DEPTH_STEP));

    // Register writes by index; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.height_gain  <= RST_GAIN;
            r_cfg.sin_pitch    <= RST_SIN;
            r_cfg.cos_pitch    <= RST_COS;
            r_cfg.sin_yaw      <= RST_SIN;
            r_cfg.cos_yaw      <= RST_COS;
            r_cfg.depth_offset <= RST_DEPTH_OFFSET;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_HEIGHT_GAIN:   r_cfg.height_gain  <= i_wr_data;
                REG_SIN_PITCH:     r_cfg.sin_pitch    <= i_wr_data;
                REG_COS_PITCH:     r_cfg.cos_pitch    <= i_wr_data;
                REG_SIN_YAW:       r_cfg.sin_yaw      <= i_wr_data;
                REG_COS_YAW:       r_cfg.cos_yaw      <= i_wr_data;
                REG_FIELD_OF_VIEW: r_cfg.depth_offset <= n_depth_offset;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/vertex_scale_rotate_offset.sv
// An accepted item passes through stage registers r1 to r6 and r_out to its result on o_out_valid.
// Throughput: one item per cycle while o_in_stall is low; the seven pipeline registers each hold one
// item, and a stall at the output fills empty stages before it reaches o_in_stall.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults:
// gain 1.0, no rotation, field of view 1.
`default_nettype none
`include "vertex_scale_rotate_offset_defines.svh"

// Top level: height scale, rotation about X then Y, depth offset, saturation.
// Depends on vsro_pkg and vsro_cfg_regs.
module vertex_scale_rotate_offset
    import vsro_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Vertex input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    // Result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    // Configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [REG_W-1:0]     i_cfg_data
);

    localparam int T = TRIG_FRAC_BITS;
    localparam logic signed [ZG_W:0]       ZS_HALF = (ZG_W+1)'(2**(HEIGHT_FRAC_BITS-1));
    localparam logic signed [R1_SUM_W-1:0] R1_HALF = R1_SUM_W'(2**(T-1));
    localparam logic signed [X2_SUM_W-1:0] X2_HALF = X2_SUM_W'(2**(T-1));
    localparam logic signed [Z2_SUM_W-1:0] Z2_HALF = Z2_SUM_W'(2**(T-1));

    t_cfg                   cfg;
    logic [NUM_STAGES-1:0]  r_vld;
    logic [NUM_STAGES-1:0]  stg_en;
    logic                   in_accept;

    // Stage 1: z times gain
    logic signed [ZG_W-1:0]       r1_zg;
    logic signed [COORD_BITS-1:0] r1_x, r1_y;
    logic                         r1_last;
    // Stage 2: rounded scaled height
    logic signed [ZS_W-1:0]       r2_zs;
    logic signed [COORD_BITS-1:0] r2_x, r2_y;
    logic                         r2_last;
    // Stage 3: products for the pitch rotation, x products for yaw
    logic signed [PC_W-1:0]       r3_ycp, r3_ysp, r3_xcy, r3_xsy;
    logic signed [PZ_W-1:0]       r3_zsp, r3_zcp;
    logic                         r3_last;
    // Stage 4: after pitch rotation
    logic signed [R1_W-1:0]       r4_y1, r4_z1;
    logic signed [PC_W-1:0]       r4_xcy, r4_xsy;
    logic                         r4_last;
    // Stage 5: z1 products for yaw
    logic signed [PZ1_W-1:0]      r5_z1sy, r5_z1cy;
    logic signed [PC_W-1:0]       r5_xcy, r5_xsy;
    logic signed [R1_W-1:0]       r5_y1;
    logic                         r5_last;
    // Stage 6: after yaw rotation and depth offset
    logic signed [X2_W-1:0]       r6_x2;
    logic signed [Z2_W-1:0]       r6_z2;
    logic signed [R1_W-1:0]       r6_y1;
    logic                         r6_last;
    // Stage 7: saturated output register
    t_out_item                    r_out;

    logic signed [ZG_W:0]         n_zs_sum;
    logic signed [R1_SUM_W-1:0]   n_y1_sum, n_z1_sum;
    logic signed [X2_SUM_W-1:0]   n_x2_sum;
    logic signed [Z2_SUM_W-1:0]   n_z2_sum;
    logic signed [Z2_SUM_W-1:0]   depth_term;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    vsro_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        stg_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign o_in_stall = !stg_en[0];
    assign in_accept  = i_in_valid && stg_en[0];

    // Valid bits travel with the items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Rounding sums: add one half, then keep the bits above the fraction.
    assign n_zs_sum = (ZG_W+1)'(r1_zg) + ZS_HALF;
    assign n_y1_sum = R1_SUM_W'(r3_ycp) - R1_SUM_W'(r3_zsp) + R1_HALF;
    assign n_z1_sum = R1_SUM_W'(r3_zcp) + R1_SUM_W'(r3_ysp) + R1_HALF;
    assign n_x2_sum = X2_SUM_W'(r5_xcy) + X2_SUM_W'(r5_z1sy) + X2_HALF;
    // The depth offset is folded in above the fraction bits before rounding.
    assign depth_term = $signed(Z2_SUM_W'(cfg.depth_offset)) <<< T;
    assign n_z2_sum = Z2_SUM_W'(r5_z1cy) - Z2_SUM_W'(r5_xsy) + Z2_HALF + depth_term;

    // Stage 1: height times gain.
    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r1_zg   <= i_in_data.z_in * cfg.height_gain;
            r1_x    <= i_in_data.x_in;
            r1_y    <= i_in_data.y_in;
            r1_last <= i_in_data.last_vertex;
        end
    end

    // Stage 2: round the scaled height.
    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r2_zs   <= n_zs_sum[ZG_W:HEIGHT_FRAC_BITS];
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_last <= r1_last;
        end
    end

    // Stage 3: the four pitch products and the two x products for yaw.
    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r3_ycp  <= r2_y * cfg.cos_pitch;
            r3_ysp  <= r2_y * cfg.sin_pitch;
            r3_zsp  <= r2_zs * cfg.sin_pitch;
            r3_zcp  <= r2_zs * cfg.cos_pitch;
            r3_xcy  <= r2_x * cfg.cos_yaw;
            r3_xsy  <= r2_x * cfg.sin_yaw;
            r3_last <= r2_last;
        end
    end

    // Stage 4: finish the pitch rotation.
    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r4_y1   <= n_y1_sum[R1_SUM_W-1:T];
            r4_z1   <= n_z1_sum[R1_SUM_W-1:T];
            r4_xcy  <= r3_xcy;
            r4_xsy  <= r3_xsy;
            r4_last <= r3_last;
        end
    end

    // Stage 5: yaw products of the rotated z.
    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r5_z1sy <= r4_z1 * cfg.sin_yaw;
            r5_z1cy <= r4_z1 * cfg.cos_yaw;
            r5_xcy  <= r4_xcy;
            r5_xsy  <= r4_xsy;
            r5_y1   <= r4_y1;
            r5_last <= r4_last;
        end
    end

    // Stage 6: finish the yaw rotation with the depth offset.
    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r6_x2   <= n_x2_sum[X2_SUM_W-1:T];
            r6_z2   <= n_z2_sum[Z2_SUM_W-1:T];
            r6_y1   <= r5_y1;
            r6_last <= r5_last;
        end
    end

    // Stage 7: saturate into the output register.
    always_ff @(posedge i_clk) begin
        if (stg_en[6]) begin
            r_out.x_out    <= sat_out(SAT_W'(r6_x2));
            r_out.y_out    <= sat_out(SAT_W'(r6_y1));
            r_out.z_out    <= sat_out(SAT_W'(r6_z2));
            r_out.last_out <= r6_last;
        end
    end

    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign o_out_data  = r_out;

    // Pipeline control checks.
    `VSRO_ASSERT_IMP(a_full_pipe_stalls_input, (&r_vld) && i_out_stall, o_in_stall,
        "full pipeline with stalled output must stall the input")
    `VSRO_ASSERT_IMP(a_free_output_frees_input, !i_out_stall, !o_in_stall,
        "input stalled although the output is free")
    `VSRO_ASSERT_NXT(a_accept_enters_stage1, in_accept, r_vld[0],
        "accepted item did not enter the first stage")
    `VSRO_ASSERT_IMP(a_result_from_stage6, $rose(o_out_valid), $past(r_vld[NUM_STAGES-2]),
        "result appeared without an item in the stage before it")

endmodule

`default_nettype wire
